@@ hw/rtl/tinymt32_generator_assert.svh @@
// ============================================================================
// TinyMT32 generator assertion macros
// Shorthand for the clocked, reset-qualified checks used in the RTL.
// ============================================================================
`ifndef TINYMT32_GENERATOR_ASSERT_SVH
`define TINYMT32_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define TMT_ASSERT_IMP(lbl, clock, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TMT_ASSERT_NXT(lbl, clock, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/tmt_pkg.sv @@
// ============================================================================
// TinyMT32 generator package
// Shared constants, command codes, controller states and control structs.
// ============================================================================
`timescale 1ns / 1ps

package tmt_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CNT_W     = 3;

    // Register reset values
    localparam logic [WORD_W-1:0] MIX_A_RESET  = 32'h8f7011ee;
    localparam logic [WORD_W-1:0] MIX_B_RESET  = 32'hfc78ff1f;
    localparam logic [WORD_W-1:0] TEMPER_RESET = 32'h3793fdff;

    // Algorithm constants
    localparam logic [WORD_W-1:0] STATE_MASK = 32'h7fffffff;
    localparam logic [WORD_W-1:0] INIT_MULT  = 32'd1812433253;
    localparam int unsigned       INIT_SHIFT = 30;
    localparam int unsigned       SH0        = 1;
    localparam int unsigned       SH1        = 10;
    localparam int unsigned       SH8        = 8;

    // First mixing round, and last mixing round and advance count
    localparam logic [CNT_W-1:0] MIX_FIRST = 3'd1;
    localparam logic [CNT_W-1:0] CNT_LAST  = 3'd7;

    // Command codes carried on tuser
    localparam logic CMD_SEED = 1'b0;
    localparam logic CMD_NEXT = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIX_A  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIX_B  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEMPER = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MIX,
        ST_ADV,
        ST_TEMPER
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic             load;
        logic             mix;
        logic             adv;
        logic             temper;
        logic [CNT_W-1:0] round;
    } tmt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } tmt_status_t;

endpackage

@@ hw/rtl/tmt_ctrl.sv @@
// ============================================================================
// TinyMT32 controller
// Sequences seeding (seven mixing rounds, eight advances) and next-word
// generation (advance, then temper into the output register).
// ============================================================================
`timescale 1ns / 1ps

module tmt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_cmd,
    output logic               in_ready,
    input  tmt_pkg::tmt_status_t status,
    output tmt_pkg::tmt_cmd_t    cmd
);

    tmt_pkg::state_t               state_reg, state_next;
    logic [tmt_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                          accept;

    assign accept = in_valid && in_ready;

    // State and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tmt_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tmt_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = (in_cmd == tmt_pkg::CMD_SEED) ? tmt_pkg::ST_MIX
                                                               : tmt_pkg::ST_TEMPER;
            end
            tmt_pkg::ST_MIX:
            begin
                if (cnt_reg == tmt_pkg::CNT_LAST)
                    state_next = tmt_pkg::ST_ADV;
            end
            tmt_pkg::ST_ADV:
            begin
                if (cnt_reg == tmt_pkg::CNT_LAST)
                    state_next = tmt_pkg::ST_IDLE;
            end
            tmt_pkg::ST_TEMPER:
            begin
                if (status.out_free)
                    state_next = tmt_pkg::ST_IDLE;
            end
            default: state_next = tmt_pkg::ST_IDLE;
        endcase
    end

    // Round / advance counter
    always_comb
    begin
        cnt_next = cnt_reg;
        unique case (state_reg)
            tmt_pkg::ST_IDLE:   cnt_next = tmt_pkg::MIX_FIRST;
            tmt_pkg::ST_MIX:    cnt_next = (cnt_reg == tmt_pkg::CNT_LAST) ? '0 : cnt_reg + 1'b1;
            tmt_pkg::ST_ADV:    cnt_next = cnt_reg + 1'b1;
            tmt_pkg::ST_TEMPER: cnt_next = cnt_reg;
            default:            cnt_next = '0;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.round  = cnt_reg;
        unique case (state_reg)
            tmt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid && (in_cmd == tmt_pkg::CMD_SEED);
                cmd.adv  = in_valid && (in_cmd == tmt_pkg::CMD_NEXT);
            end
            tmt_pkg::ST_MIX:    cmd.mix    = 1'b1;
            tmt_pkg::ST_ADV:    cmd.adv    = 1'b1;
            tmt_pkg::ST_TEMPER: cmd.temper = status.out_free;
            default:            cmd        = '0;
        endcase
    end

endmodule

@@ hw/rtl/tmt_dp.sv @@
// ============================================================================
// TinyMT32 datapath
// State words, parameter registers, mixing round, advance, tempering and the
// output word register.
// ============================================================================
`timescale 1ns / 1ps

module tmt_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tmt_pkg::tmt_cmd_t                 cmd,
    output tmt_pkg::tmt_status_t              status,
    input  logic [tmt_pkg::WORD_W-1:0]        seed,
    input  logic                              cfg_we,
    input  logic [tmt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tmt_pkg::WORD_W-1:0]        cfg_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tmt_pkg::WORD_W-1:0]        out_word
);

    localparam int unsigned W = tmt_pkg::WORD_W;

    logic [W-1:0] w0_reg, w1_reg, w2_reg, w3_reg;
    logic [W-1:0] w0_next, w1_next, w2_next, w3_next;
    logic [W-1:0] mix_a_reg, mix_b_reg, temper_reg;
    logic         out_valid_reg, out_valid_next;
    logic [W-1:0] out_reg;

    logic [W-1:0] adv_x, adv_y, adv_sel;
    logic [W-1:0] mix_val, mix_term, mix_w1;
    logic [W-1:0] t_sum, t_word;

    // Advance: one xor-shift step on the four words
    always_comb
    begin
        adv_x   = (w0_reg & tmt_pkg::STATE_MASK) ^ w1_reg ^ w2_reg;
        adv_x   = adv_x ^ (adv_x << tmt_pkg::SH0);
        adv_y   = w3_reg ^ (w3_reg >> tmt_pkg::SH0) ^ adv_x;
        adv_sel = {W{adv_y[0]}};
    end

    // Mixing round: word 0 is the previous word, word 1 the target; words
    // rotate one place per round (two on the last) so they end realigned
    always_comb
    begin
        mix_val  = w0_reg ^ (w0_reg >> tmt_pkg::INIT_SHIFT);
        mix_term = mix_val * tmt_pkg::INIT_MULT;
        mix_w1   = w1_reg ^ (mix_term + W'(cmd.round));
    end

    // Tempering of the current state
    always_comb
    begin
        t_sum  = w0_reg + (w2_reg >> tmt_pkg::SH8);
        t_word = w3_reg ^ t_sum ^ ({W{t_sum[0]}} & temper_reg);
    end

    // State word update
    always_comb
    begin
        w0_next = w0_reg;
        w1_next = w1_reg;
        w2_next = w2_reg;
        w3_next = w3_reg;
        priority if (cmd.load)
        begin
            w0_next = seed;
            w1_next = mix_a_reg;
            w2_next = mix_b_reg;
            w3_next = temper_reg;
        end
        else if (cmd.mix)
        begin
            if (cmd.round == tmt_pkg::CNT_LAST)
            begin
                w0_next = w2_reg;
                w1_next = w3_reg;
                w2_next = w0_reg;
                w3_next = mix_w1;
            end
            else
            begin
                w0_next = mix_w1;
                w1_next = w2_reg;
                w2_next = w3_reg;
                w3_next = w0_reg;
            end
        end
        else if (cmd.adv)
        begin
            w0_next = w1_reg;
            w1_next = w2_reg ^ (adv_sel & mix_a_reg);
            w2_next = adv_x ^ (adv_y << tmt_pkg::SH1) ^ (adv_sel & mix_b_reg);
            w3_next = adv_y;
        end
    end

    // State words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w0_reg <= '0;
            w1_reg <= '0;
            w2_reg <= '0;
            w3_reg <= '0;
        end
        else
        begin
            w0_reg <= w0_next;
            w1_reg <= w1_next;
            w2_reg <= w2_next;
            w3_reg <= w3_next;
        end
    end

    // Parameter registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_a_reg  <= tmt_pkg::MIX_A_RESET;
            mix_b_reg  <= tmt_pkg::MIX_B_RESET;
            temper_reg <= tmt_pkg::TEMPER_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == tmt_pkg::REG_MIX_A)
                mix_a_reg <= cfg_data;
            if (cfg_index == tmt_pkg::REG_MIX_B)
                mix_b_reg <= cfg_data;
            if (cfg_index == tmt_pkg::REG_TEMPER)
                temper_reg <= cfg_data;
        end
    end

    // Output word register
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid_next  = cmd.temper || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.temper)
            out_reg <= t_word;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

@@ hw/rtl/tinymt32_generator.sv @@
// Next word: accepted and advanced in that cycle, then tempered into the output
//   register once it is free; no new command is taken until the word is tempered.
// Seed: 1 load + 7 mixing rounds (one multiply per round) + 8 advances, no
//   output word. Input is held off until the sequence is done.
// Reset (rst_n, async low): state words cleared, parameter registers loaded
//   with their defaults, output empty. Configuration is always ready.
// ============================================================================
// TinyMT32 generator top level
// Stream-in commands, stream-out tempered 32-bit random words.
// ============================================================================
`timescale 1ns / 1ps

`include "tinymt32_generator_assert.svh"

module tinymt32_generator (
    input  logic                          clk,
    input  logic                          rst_n,
    // Command input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tmt_pkg::WORD_W-1:0]    s_tdata,   // [31:0] seed_value
    input  logic [0:0]                    s_tuser,   // [0] cmd
    // Random word output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tmt_pkg::WORD_W-1:0]    m_tdata,   // [31:0] random_word
    // Configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tmt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tmt_pkg::WORD_W-1:0]    cfg_data
);

    tmt_pkg::tmt_cmd_t    cmd;
    tmt_pkg::tmt_status_t status;

    assign cfg_ready = 1'b1;

    // Controller
    tmt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_cmd   (s_tuser[0]),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    tmt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .seed      (s_tdata),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (m_tdata)
    );

    // Checks
    `TMT_ASSERT_IMP(a_cmd_onehot, clk, rst_n, 1'b1,
        $onehot0({cmd.load, cmd.mix, cmd.adv, cmd.temper}),
        "more than one datapath command active")
    `TMT_ASSERT_NXT(a_next_busy, clk, rst_n,
        s_tvalid && s_tready && (s_tuser[0] == tmt_pkg::CMD_NEXT),
        !s_tready && !cmd.load,
        "input taken while a next word is pending")
    `TMT_ASSERT_NXT(a_seed_mix, clk, rst_n,
        s_tvalid && s_tready && (s_tuser[0] == tmt_pkg::CMD_SEED),
        cmd.mix && (cmd.round == tmt_pkg::MIX_FIRST),
        "seed did not start with the first mixing round")
    `TMT_ASSERT_IMP(a_word_source, clk, rst_n, $rose(m_tvalid), $past(cmd.temper),
        "output word appeared without tempering")

endmodule

@@ dv/tinymt32_generator_checker.sv @@
// ============================================================================
// TinyMT32 generator stream checker
// Watches the command, result and configuration channels, keeps its own copy
// of the generator state and parameter registers, predicts every random word
// and compares it with what the generator sends out.
// ============================================================================
`timescale 1ns / 1ps

module tinymt32_generator_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    // Command input, as seen at the generator
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [tmt_pkg::WORD_W-1:0]    s_tdata,   // [31:0] seed_value
    input  logic [0:0]                    s_tuser,   // [0] cmd
    // Random word output
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [tmt_pkg::WORD_W-1:0]    m_tdata,   // [31:0] random_word
    // Configuration writes
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [tmt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tmt_pkg::WORD_W-1:0]    cfg_data,
    // Status to the testbench top
    output int unsigned                   fail_count,
    output int unsigned                   pending_words,
    output int unsigned                   words_checked
);

    import tmt_pkg::*;

    localparam int unsigned REPORT_LIMIT = 10;

    // Shadow of the generator state and parameter registers
    logic [WORD_W-1:0] gen_state [4];
    logic [WORD_W-1:0] mix_a;
    logic [WORD_W-1:0] mix_b;
    logic [WORD_W-1:0] temper_mask;

    // Random words predicted but not yet seen on the output
    logic [WORD_W-1:0] predicted_words [$];

    int unsigned fails;
    int unsigned checked;

    // One state advance
    function void tmt_advance();
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        begin
            x = (gen_state[0] & STATE_MASK) ^ gen_state[1] ^ gen_state[2];
            y = gen_state[3];
            x = x ^ (x << SH0);
            y = y ^ (y >> SH0) ^ x;
            gen_state[0] = gen_state[1];
            gen_state[1] = gen_state[2];
            gen_state[2] = x ^ (y << SH1);
            gen_state[3] = y;
            if (y[0])
            begin
                gen_state[1] = gen_state[1] ^ mix_a;
                gen_state[2] = gen_state[2] ^ mix_b;
            end
        end
    endfunction

    // Tempered output word from the current state
    function logic [WORD_W-1:0] tmt_temper();
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] t;
        begin
            sum = gen_state[0] + (gen_state[2] >> SH8);
            t   = gen_state[3] ^ sum;
            if (sum[0])
                t = t ^ temper_mask;
            return t;
        end
    endfunction

    // Seed load: mixing rounds 1..7, then eight advances
    function void tmt_seed(input logic [WORD_W-1:0] seed);
        logic [WORD_W-1:0] round;
        logic [WORD_W-1:0] prev;
        int                k;
        begin
            gen_state[0] = seed;
            gen_state[1] = mix_a;
            gen_state[2] = mix_b;
            gen_state[3] = temper_mask;
            for (round = WORD_W'(MIX_FIRST); round <= WORD_W'(CNT_LAST); round++)
            begin
                prev = gen_state[round[1:0] - 2'd1];
                gen_state[round[1:0]] = gen_state[round[1:0]]
                    ^ (round + INIT_MULT * (prev ^ (prev >> INIT_SHIFT)));
            end
            for (k = 0; k <= int'(CNT_LAST); k++)
                tmt_advance();
        end
    endfunction

    // Channel monitor: result first, then config, then command
    always @(posedge clk or negedge rst_n)
    begin
        logic [WORD_W-1:0] want;
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
                gen_state[k] = '0;
            mix_a       = MIX_A_RESET;
            mix_b       = MIX_B_RESET;
            temper_mask = TEMPER_RESET;
            predicted_words.delete();
            fails   = 0;
            checked = 0;
            fail_count    <= 0;
            pending_words <= 0;
            words_checked <= 0;
        end
        else
        begin
            // Random word out
            if (m_tvalid && m_tready)
            begin
                if (predicted_words.size() == 0)
                begin
                    fails++;
                    if (fails <= REPORT_LIMIT)
                        $display("%0t: unexpected random word %h, none predicted",
                                 $realtime, m_tdata);
                end
                else
                begin
                    want = predicted_words.pop_front();
                    checked++;
                    if (m_tdata !== want)
                    begin
                        fails++;
                        if (fails <= REPORT_LIMIT)
                            $display("%0t: random_word mismatch, expected %h got %h",
                                     $realtime, want, m_tdata);
                    end
                end
            end

            // Register write; out-of-range index is dropped
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MIX_A:  mix_a       = cfg_data;
                    REG_MIX_B:  mix_b       = cfg_data;
                    REG_TEMPER: temper_mask = cfg_data;
                    default:    ;
                endcase
            end

            // Command word in
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0] == CMD_NEXT)
                begin
                    tmt_advance();
                    predicted_words.push_back(tmt_temper());
                end
                else
                    tmt_seed(s_tdata);
            end

            fail_count    <= fails;
            pending_words <= predicted_words.size();
            words_checked <= checked;
        end
    end

endmodule

@@ dv/tinymt32_generator_tb.sv @@
// ============================================================================
// TinyMT32 generator testbench
// Drives seed and next commands with random gaps, random output back-pressure
// and one long receiver hold-off, reprograms the parameter registers between
// phases, and takes the verdict from the stream checker.
// ============================================================================
`timescale 1ns / 1ps

module tinymt32_generator_tb;

    import tmt_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int unsigned RESET_CYCLES    = 6;
    localparam int unsigned SETTLE_CYCLES   = 24;
    localparam int unsigned WATCHDOG_LIMIT  = 1000;
    localparam int unsigned HOLD_AT         = 600;
    localparam int unsigned HOLD_CYCLES     = 160;
    localparam int unsigned RANDOM_PHASES   = 4;
    localparam int unsigned PHASE_WORDS     = 420;
    localparam int unsigned SEED_PERCENT    = 4;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [WORD_W-1:0]    s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [WORD_W-1:0]    m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    int unsigned fail_count;
    int unsigned pending_words;
    int unsigned words_checked;

    int unsigned sent_count;
    int unsigned seeds_sent;
    int unsigned nexts_sent;
    int unsigned settings_used;
    int unsigned quiet_cycles;
    bit          no_gaps;

    // Clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    tinymt32_generator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tinymt32_generator_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_words (pending_words),
        .words_checked (words_checked)
    );

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                return 0;
            else if (r < 90)
                return $urandom_range(1, 3);
            else if (r < 98)
                return $urandom_range(4, 12);
            else
                return $urandom_range(20, 60);
        end
    endfunction

    // Parameter value with the extremes weighted in
    function automatic logic [WORD_W-1:0] pick_word();
        int unsigned r;
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                return '0;
            else if (r == 1)
                return '1;
            else
                return $urandom;
        end
    endfunction

    // Send one command word; valid stays high into the next word if no gap
    task automatic send_word(input logic cmd, input logic [WORD_W-1:0] seed);
        int unsigned gap;
        begin
            gap = no_gaps ? 0 : pick_gap();
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= cmd;
            s_tdata  <= seed;
            do @(posedge clk); while (!s_tready);
            sent_count++;
            if (cmd == CMD_SEED)
                seeds_sent++;
            else
                nexts_sent++;
        end
    endtask

    // Stop sending and wait until every predicted word is out and the
    // generator has had time to finish a trailing seed
    task automatic settle();
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while (pending_words != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    // Write all three registers plus one out-of-range index
    task automatic program_regs(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b,
                                input logic [WORD_W-1:0] t, input logic [WORD_W-1:0] junk);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [WORD_W-1:0]    val [4];
        int                   k;
        begin
            idx = '{REG_MIX_A, REG_MIX_B, REG_TEMPER, REG_UNUSED};
            val = '{a, b, t, junk};
            for (k = 0; k < 4; k++)
            begin
                cfg_valid <= 1'b1;
                cfg_index <= idx[k];
                cfg_data  <= val[k];
                do @(posedge clk); while (!cfg_ready);
            end
            cfg_valid <= 1'b0;
            settings_used++;
        end
    endtask

    // Receiver: stretches of full rate and of random stalls, one long hold-off
    initial
    begin
        int unsigned stall_left;
        int unsigned mode_left;
        int unsigned r;
        bit          relaxed;
        bit          hold_done;
        stall_left = 0;
        mode_left  = 0;
        relaxed    = 1'b0;
        hold_done  = 1'b0;
        forever
        begin
            if (stall_left != 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (!hold_done && sent_count >= HOLD_AT)
            begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES - 1;
                m_tready  <= 1'b0;
            end
            else if (mode_left == 0)
            begin
                relaxed   = $urandom_range(0, 1);
                mode_left = $urandom_range(50, 300);
                m_tready <= 1'b1;
            end
            else
            begin
                mode_left--;
                r = $urandom_range(0, 99);
                if (!relaxed || r < 70)
                    m_tready <= 1'b1;
                else
                begin
                    stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
                    m_tready  <= 1'b0;
                end
            end
            @(posedge clk);
        end
    end

    // Watchdog: too long with no word moving on any channel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("%0t: timeout, %0d words still outstanding", $realtime, pending_words);
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Stimulus and verdict
    initial
    begin
        int unsigned phase;
        int unsigned n;
        sent_count    = 0;
        seeds_sent    = 0;
        nexts_sent    = 0;
        settings_used = 0;
        no_gaps       = 1'b0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= CMD_SEED;
        cfg_valid <= 1'b0;
        cfg_index <= REG_MIX_A;
        cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Next from the all-zero state before any seed
        repeat (3) send_word(CMD_NEXT, $urandom);
        // Seed extremes under the reset parameters
        send_word(CMD_SEED, '0);
        repeat (2) send_word(CMD_NEXT, $urandom);
        send_word(CMD_SEED, '1);
        repeat (2) send_word(CMD_NEXT, $urandom);

        // Parameters changed after seeding, no reseed
        settle();
        program_regs('0, '0, '0, '1);
        repeat (2) send_word(CMD_NEXT, '1);
        send_word(CMD_SEED, 32'h0000_0001);
        send_word(CMD_NEXT, '0);

        settle();
        program_regs('1, '1, '1, '0);
        repeat (2) send_word(CMD_NEXT, $urandom);
        send_word(CMD_SEED, 32'h8000_0000);
        repeat (2) send_word(CMD_NEXT, $urandom);

        // Random phases, each under its own register setting
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle();
            if (phase == 1)
                program_regs(MIX_A_RESET, MIX_B_RESET, TEMPER_RESET, $urandom);
            else
                program_regs(pick_word(), pick_word(), pick_word(), $urandom);
            no_gaps = (phase == 2);
            send_word(CMD_SEED, $urandom);
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                if ($urandom_range(0, 99) < SEED_PERCENT)
                    send_word(CMD_SEED, $urandom);
                else
                    send_word(CMD_NEXT, $urandom);
            end
        end

        settle();

        $display("Sent %0d command words (%0d seeds, %0d next) under %0d register settings.",
                 sent_count, seeds_sent, nexts_sent, settings_used + 1);
        $display("Compared %0d random words; output held off once for %0d cycles.",
                 words_checked, HOLD_CYCLES);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
